FILE: design/polsc_pkg.sv
// Shared types and constants for the polar SC decoder.
package polsc_pkg;

  localparam int CODE_LEN_DEF  = 32;
  localparam int LLR_WIDTH_DEF = 8;
  localparam int IN_WIDTH      = 8;
  localparam int OUT_WIDTH     = 32;
  localparam int MASK_WIDTH    = 32;
  // command field widths cover CODE_LEN up to 1024
  localparam int CMD_DEPTH_W   = 4;
  localparam int CMD_IDX_W     = 10;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ENTER,
    ST_RD,
    ST_WR,
    ST_WR2,
    ST_RET,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    KIND_F,
    KIND_G,
    KIND_CMB,
    KIND_LEAF
  } kind_t;

  typedef struct packed {
    logic                   load;
    logic                   clr;
    logic                   wr;
    logic                   wr2;
    logic                   out_load;
    kind_t                  kind;
    logic [CMD_DEPTH_W-1:0] depth;
    logic [CMD_IDX_W-1:0]   idx;
    logic [CMD_IDX_W-1:0]   base;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

FILE: design/polsc_ram.sv
// Generic RAM: one write port, two registered read ports.
module polsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a_r,
  output logic [WIDTH-1:0]         rdata_b_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

endmodule

FILE: design/polsc_ctrl.sv
// Controller: load counting and the SC node schedule.
module polsc_ctrl #(
  parameter int CODE_LEN = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  polsc_pkg::stat_t stat,
  output polsc_pkg::cmd_t  cmd
);
  import polsc_pkg::*;

  localparam int LOG_N = $clog2(CODE_LEN);
  localparam int DW    = $clog2(LOG_N + 1);
  localparam int LW    = LOG_N + 1;

  state_t           state_r, state_nxt;
  kind_t            kind_r, kind_nxt;
  logic [DW-1:0]    depth_r, depth_nxt;
  logic [LOG_N-1:0] idx_r, idx_nxt;
  logic [LOG_N-1:0] base_r, base_nxt;
  logic [LW-1:0]    half_w;
  logic [LW-1:0]    clen_w;
  logic             last_elem;
  logic             last_load;

  // lengths at the current depth
  assign half_w    = LW'(CODE_LEN) >> ({1'b0, depth_r} + 1'b1);
  assign clen_w    = LW'(CODE_LEN) >> depth_r;
  assign last_elem = (LW'(idx_r) == (half_w - 1'b1));
  assign last_load = (idx_r == LOG_N'(CODE_LEN - 1));

  // next state and loop counters
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    depth_nxt = depth_r;
    idx_nxt   = idx_r;
    base_nxt  = base_r;
    unique case (state_r) inside
      ST_LOAD: begin
        if (in_tvalid) begin
          idx_nxt = idx_r + 1'b1;
          if (last_load) begin
            idx_nxt   = '0;
            depth_nxt = '0;
            base_nxt  = '0;
            state_nxt = ST_ENTER;
          end
        end
      end
      ST_ENTER: begin
        idx_nxt   = '0;
        kind_nxt  = (depth_r == DW'(LOG_N)) ? KIND_LEAF : KIND_F;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_WR;
      end
      ST_WR, ST_WR2: begin
        if (state_r == ST_WR && kind_r == KIND_CMB) begin
          state_nxt = ST_WR2;
        end else if (kind_r == KIND_LEAF) begin
          state_nxt = ST_RET;
        end else if (last_elem) begin
          unique case (kind_r)
            KIND_F: begin
              depth_nxt = depth_r + 1'b1;
              state_nxt = ST_ENTER;
            end
            KIND_G: begin
              base_nxt  = base_r + LOG_N'(half_w);
              depth_nxt = depth_r + 1'b1;
              state_nxt = ST_ENTER;
            end
            default: begin
              state_nxt = ST_RET;
            end
          endcase
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RET: begin
        idx_nxt = '0;
        if (depth_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          depth_nxt = depth_r - 1'b1;
          state_nxt = ST_RD;
          if ((base_r & LOG_N'(clen_w)) == '0) begin
            kind_nxt = KIND_G;
          end else begin
            kind_nxt = KIND_CMB;
            base_nxt = base_r - LOG_N'(clen_w);
          end
        end
      end
      ST_OUT: begin
        idx_nxt = '0;
        if (stat.out_free) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.kind     = kind_r;
    cmd.depth    = CMD_DEPTH_W'(depth_r);
    cmd.idx      = CMD_IDX_W'(idx_r);
    cmd.base     = CMD_IDX_W'(base_r);
    in_tready    = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        cmd.clr   = in_tvalid && last_load;
      end
      ST_WR:  cmd.wr       = 1'b1;
      ST_WR2: cmd.wr2      = 1'b1;
      ST_OUT: cmd.out_load = stat.out_free;
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      kind_r  <= KIND_F;
      depth_r <= '0;
      idx_r   <= '0;
      base_r  <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      depth_r <= depth_nxt;
      idx_r   <= idx_nxt;
      base_r  <= base_nxt;
    end
  end

endmodule

FILE: design/polsc_dp.sv
// Datapath: LLR and partial-sum RAMs, f/g units, decisions and result register.
module polsc_dp #(
  parameter int CODE_LEN  = 32,
  parameter int LLR_WIDTH = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  polsc_pkg::cmd_t                        cmd,
  output polsc_pkg::stat_t                       stat,
  input  logic [polsc_pkg::IN_WIDTH-1:0]         in_tdata,
  input  logic                                   cfg_wr_en,
  input  logic [polsc_pkg::MASK_WIDTH-1:0]       cfg_wr_data,
  input  logic                                   out_tready,
  output logic                                   out_tvalid,
  output logic [polsc_pkg::OUT_WIDTH-1:0]        out_tdata
);
  import polsc_pkg::*;

  localparam int BUF = 2 * CODE_LEN;
  localparam int AW  = $clog2(BUF);
  localparam int EW  = 17;
  localparam logic signed [EW-1:0] LMAX = EW'((1 << (LLR_WIDTH - 1)) - 1);
  localparam logic signed [EW-1:0] LMIN = -LMAX - 1;

  logic [MASK_WIDTH-1:0] frozen_r;
  logic [OUT_WIDTH-1:0]  dec_r;
  logic [OUT_WIDTH-1:0]  out_data_r;
  logic                  out_valid_r;

  logic [AW:0] len_w, off_w, half_w, child_w, i_w;
  logic [AW-1:0] llr_waddr, llr_ra, llr_rb, ps_waddr, ps_ra, ps_rb;
  logic [LLR_WIDTH-1:0] llr_wdata, llr_a, llr_b;
  logic llr_we, ps_we, ps_wdata, ps_a, ps_b;
  logic signed [EW-1:0] in_ext, a_ext, b_ext, f_res, g_res;
  logic [31:0] base32;
  logic [4:0]  bidx;
  logic        leaf_u;

  function automatic logic [LLR_WIDTH-1:0] sat(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] r;
    r = v;
    if (v > LMAX) r = LMAX;
    if (v < LMIN) r = LMIN;
    return r[LLR_WIDTH-1:0];
  endfunction

  // node geometry at the commanded depth
  assign len_w   = (AW+1)'(CODE_LEN) >> cmd.depth;
  assign off_w   = (AW+1)'(BUF) - (len_w << 1);
  assign half_w  = len_w >> 1;
  assign child_w = off_w + len_w;
  assign i_w     = (AW+1)'(cmd.idx);

  // read addresses
  assign llr_ra = AW'(off_w + i_w);
  assign llr_rb = AW'(off_w + half_w + i_w);
  assign ps_ra  = (cmd.kind == KIND_G) ? AW'(child_w + i_w) : AW'(off_w + i_w);
  assign ps_rb  = AW'(child_w + i_w);

  // f and g in extended precision
  assign in_ext = EW'(signed'(in_tdata));
  assign a_ext  = EW'(signed'(llr_a));
  assign b_ext  = EW'(signed'(llr_b));

  always_comb begin
    logic signed [EW-1:0] ma, mb, m;
    logic pos;
    ma    = (a_ext < 0) ? -a_ext : a_ext;
    mb    = (b_ext < 0) ? -b_ext : b_ext;
    m     = (ma < mb) ? ma : mb;
    pos   = (a_ext > 0 && b_ext > 0) || (a_ext < 0 && b_ext < 0);
    f_res = pos ? m : -m;
    g_res = (ps_a ? -a_ext : a_ext) + b_ext;
  end

  // leaf decision, frozen only within the mask range
  assign base32 = 32'(cmd.base);
  assign bidx   = 5'(cmd.base);
  assign leaf_u = llr_a[LLR_WIDTH-1] && !(base32 < 32 && frozen_r[bidx]);

  // LLR write port
  always_comb begin
    llr_we    = 1'b0;
    llr_waddr = AW'(child_w + i_w);
    llr_wdata = sat(f_res);
    if (cmd.load) begin
      llr_we    = 1'b1;
      llr_waddr = AW'(cmd.idx);
      llr_wdata = sat(in_ext);
    end else if (cmd.wr && cmd.kind == KIND_F) begin
      llr_we = 1'b1;
    end else if (cmd.wr && cmd.kind == KIND_G) begin
      llr_we    = 1'b1;
      llr_wdata = sat(g_res);
    end
  end

  // partial-sum write port
  always_comb begin
    ps_we    = 1'b0;
    ps_waddr = AW'(off_w + i_w);
    ps_wdata = ps_a;
    if (cmd.wr2) begin
      ps_we    = 1'b1;
      ps_waddr = AW'(off_w + half_w + i_w);
      ps_wdata = ps_b;
    end else if (cmd.wr) begin
      ps_we = 1'b1;
      case (cmd.kind)
        KIND_CMB:  ps_wdata = ps_a ^ ps_b;
        KIND_LEAF: ps_wdata = leaf_u;
        KIND_G:    ps_wdata = ps_a;
        default:   ps_we    = 1'b0;
      endcase
    end
  end

  polsc_ram #(.WIDTH(LLR_WIDTH), .DEPTH(BUF)) u_llr_ram (
    .clk       (clk),
    .we        (llr_we),
    .waddr     (llr_waddr),
    .wdata     (llr_wdata),
    .raddr_a   (llr_ra),
    .raddr_b   (llr_rb),
    .rdata_a_r (llr_a),
    .rdata_b_r (llr_b)
  );

  polsc_ram #(.WIDTH(1), .DEPTH(BUF)) u_ps_ram (
    .clk       (clk),
    .we        (ps_we),
    .waddr     (ps_waddr),
    .wdata     (ps_wdata),
    .raddr_a   (ps_ra),
    .raddr_b   (ps_rb),
    .rdata_a_r (ps_a),
    .rdata_b_r (ps_b)
  );

  // frozen mask, decisions and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frozen_r    <= '0;
      dec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) frozen_r <= cfg_wr_data;
      if (cmd.clr) begin
        dec_r <= '0;
      end else if (cmd.wr && cmd.kind == KIND_LEAF && base32 < 32 && leaf_u) begin
        dec_r[bidx] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= dec_r;
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

endmodule

FILE: design/polar_sc_decoder_core.sv
// Top level of the min-sum successive-cancellation polar decoder.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata[7:0]   llr
//  out_    | out | out_tvalid/out_tready| out_tdata[31:0] decoded_bits
//  cfg_    | in  | cfg_wr_en            | cfg_wr_data[31:0] frozen_mask
//
// Load takes one LLR per cycle.
// Decode then steps through the butterfly elements one at a time, each read from and
// written back to the LLR and partial-sum RAMs.
// Input stalls during decode and while a finished word waits for out_tready.
// rst_n is synchronous, active low; it clears control state and the frozen mask.
module polar_sc_decoder_core #(
  parameter int CODE_LEN  = polsc_pkg::CODE_LEN_DEF,
  parameter int LLR_WIDTH = polsc_pkg::LLR_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [polsc_pkg::IN_WIDTH-1:0]    in_tdata,    // [7:0] llr
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [polsc_pkg::OUT_WIDTH-1:0]   out_tdata,   // [31:0] decoded_bits
  input  logic                              cfg_wr_en,
  input  logic [polsc_pkg::MASK_WIDTH-1:0]  cfg_wr_data
);
  import polsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  polsc_ctrl #(.CODE_LEN(CODE_LEN)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  polsc_dp #(.CODE_LEN(CODE_LEN), .LLR_WIDTH(LLR_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata)
  );

`ifndef SYNTHESIS
  // loading never overlaps a datapath write phase
  a_load_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.wr && !cmd.wr2)
    else $error("load overlaps write phase");

  // a new result never overwrites one still pending
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result overwritten");

  // second write only directly after the first write of a combine
  a_wr2_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr2 |-> $past(cmd.wr) && cmd.kind == KIND_CMB)
    else $error("stray second write");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the min-sum SC polar decoder core.
`timescale 1ns / 100ps

module tb;
  import polsc_pkg::*;

  localparam int N         = 32;
  localparam int N_RANDOM  = 1520;
  localparam int IDLE_PCT  = 23;
  localparam int DRAIN_CYC = 1200;
  localparam int WD_LIMIT  = 20000;
  localparam int HOLD_CYC  = 3000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_WIDTH-1:0]   in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_WIDTH-1:0]  out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [MASK_WIDTH-1:0] cfg_wr_data = '0;

  always #5 clk = ~clk;

  polar_sc_decoder_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // [7:0] llr
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // [31:0] decoded_bits
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // decoder model state
  logic signed [7:0]     chan_llr [N];
  int                    chan_cnt;
  logic [MASK_WIDTH-1:0] frozen_bits;
  logic [31:0]           word_q[$];
  int                    errors;
  int                    words_seen;
  int                    idle_cnt;
  bit                    calm;       // no random idling
  bit                    hold_rx;    // receiver hold-off in progress

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %08h expected %08h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  function automatic logic signed [7:0] clip(input int v);
    if (v > 127) return 8'sd127;
    if (v < -128) return -8'sd128;
    return v[7:0];
  endfunction

  function automatic logic signed [7:0] min_sum(input int a, input int b);
    int m;
    m = ((a < 0 ? -a : a) < (b < 0 ? -b : b)) ? (a < 0 ? -a : a) : (b < 0 ? -b : b);
    return clip(((a > 0 && b > 0) || (a < 0 && b < 0)) ? m : -m);
  endfunction

  // recursive SC: returns the node's partial sums in the low len bits
  function automatic logic [31:0] sc_decode(input int llrs[], input int len, input int first,
                                            inout logic [31:0] bits);
    int          lo[];
    int          half;
    logic [31:0] left, right;
    bit          u;
    if (len == 1) begin
      u = (llrs[0] < 0) && !frozen_bits[first];
      if (u) bits[first] = 1'b1;
      return {31'b0, u};
    end
    half = len / 2;
    lo = new[half];
    for (int i = 0; i < half; i++) lo[i] = min_sum(llrs[i], llrs[i+half]);
    left = sc_decode(lo, half, first, bits);
    for (int i = 0; i < half; i++)
      lo[i] = clip((left[i] ? -llrs[i] : llrs[i]) + llrs[i+half]);
    right = sc_decode(lo, half, first + half, bits);
    return ((left ^ right) & ((32'd1 << half) - 1)) | (right << half);
  endfunction

  function automatic logic [31:0] decode_word();
    int          v[];
    logic [31:0] bits;
    v = new[N];
    for (int i = 0; i < N; i++) v[i] = chan_llr[i];
    bits = '0;
    void'(sc_decode(v, N, 0, bits));
    return bits;
  endfunction

  // send one LLR; push the expected word on codeword completion
  task automatic send_llr(input logic [7:0] llr, input bit has_exp = 0,
                          input logic [31:0] exp = '0);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < IDLE_PCT);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= llr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chan_llr[chan_cnt] = llr;
    chan_cnt++;
    if (chan_cnt == N) begin
      chan_cnt = 0;
      word_q.push_back(has_exp ? exp : decode_word());
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (word_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_mask(input logic [31:0] m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    frozen_bits = m;
    @(posedge clk);
  endtask

  // receiver: random stalls, hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_rx && (calm || $urandom_range(99) >= IDLE_PCT);
      if (out_tvalid && out_tready) begin
        words_seen++;
        if (word_q.size() == 0) report("unexpected word", out_tdata, 32'h0);
        else begin
          if (out_tdata !== word_q[0]) report("decoded_bits", out_tdata, word_q[0]);
          void'(word_q.pop_front());
        end
      end
    end
  end

  // watchdog on accepted requests
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WD_LIMIT) begin
      $display("watchdog expired, %0d words outstanding", word_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // directed codewords: {fill llr, mask, expected word when obvious}
  typedef struct {
    logic [7:0]  llr;
    logic [31:0] mask;
    bit          has_exp;
    logic [31:0] exp;
  } dir_row_t;

  dir_row_t dir_tab[] = '{
    '{8'h00, 32'h0000_0000, 1, 32'h0000_0000},  // all-zero LLRs decide zero
    '{8'h7F, 32'h0000_0000, 1, 32'h0000_0000},  // strong zeros
    '{8'h80, 32'h0000_0000, 0, 32'h0},          // most negative, saturating g
    '{8'hFF, 32'h0000_0000, 0, 32'h0},
    '{8'h80, 32'hFFFF_FFFF, 1, 32'h0000_0000}   // fully frozen
  };

  initial begin
    int          nitems;
    logic [31:0] masks[4];
    masks = '{32'h0, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0};
    errors = 0; words_seen = 0; chan_cnt = 0; frozen_bits = '0;
    calm = 0; hold_rx = 0; idle_cnt = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: uniform codewords over the table (each row fills one word)
    foreach (dir_tab[r]) begin
      if (dir_tab[r].mask != frozen_bits) begin
        wait_idle();
        write_mask(dir_tab[r].mask);
      end
      for (int i = 0; i < N; i++) send_llr(dir_tab[r].llr, dir_tab[r].has_exp, dir_tab[r].exp);
    end
    // alternating extremes, checked against the predictor
    wait_idle();
    write_mask(32'h0);
    for (int i = 0; i < N; i++) send_llr(i[0] ? 8'h80 : 8'h7F);

    // random: four mask phases, mixed LLR magnitudes
    nitems = 0;
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_mask(ph == 3 ? $urandom() : masks[ph]);
      calm = (ph == 1);
      if (ph == 2) begin
        hold_rx = 1;
        fork
          begin repeat (HOLD_CYC) @(posedge clk); hold_rx = 0; end
        join_none
      end
      for (int k = 0; k < N_RANDOM / (4 * N); k++) begin
        for (int i = 0; i < N; i++) begin
          case ($urandom_range(3))
            0: send_llr(8'($urandom_range(255)));
            1: send_llr($urandom_range(1) ? 8'h7F : 8'h80);
            default: send_llr(8'($signed($urandom_range(8)) - 4));
          endcase
          nitems++;
        end
        // sender pause until all results have come
        if (k == 3) begin
          in_tvalid <= 1'b0;
          while (word_q.size() != 0) @(posedge clk);
        end
      end
      calm = 0;
    end

    wait_idle();
    $display("covered %0d random LLRs plus directed extremes over four frozen-mask settings",
             nitems);
    $display("%0d codewords decoded and compared, %0d mismatches", words_seen, errors);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
design/polsc_pkg.sv
design/polsc_ram.sv
design/polsc_ctrl.sv
design/polsc_dp.sv
design/polar_sc_decoder_core.sv
tb/tb.sv
